// File: sv/cbo_pkg.sv
`timescale 1ns / 1ps

package cbo_pkg;

    localparam int ANG_W = 20;
    localparam int CQ_W = 33;
    localparam int CORDIC_STEPS = 17;

    localparam logic signed [ANG_W-1:0] PI_Q16 = 20'sd205887;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [34:0] TWO_PI_Q16 = 35'd411775;
    localparam logic signed [CQ_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic [31:0] STEER_K = 32'd4497679;
    localparam logic [15:0] STEER_RAW_MAX = 16'd1000;
    localparam logic signed [10:0] STEER_RAW_MID = 11'sd500;
    localparam logic [34:0] POS_DEN = 35'd16384000000;
    localparam logic [63:0] POS_HALF = 64'd8192000000;
    localparam logic [31:0] LEN_SCALE = 32'd1000;
    localparam logic signed [18:0] HEADING_MAX = 19'sd205887;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        CFG_SPEED_ID,
        CFG_STEER_ID,
        CFG_WHEELBASE,
        CFG_TICK_MS
    } cfg_index_t;

    function automatic logic [15:0] cbo_atan(input logic [4:0] idx);
        logic [15:0] r;
        case (idx)
            5'd0: r = 16'd51472;
            5'd1: r = 16'd30386;
            5'd2: r = 16'd16055;
            5'd3: r = 16'd8150;
            5'd4: r = 16'd4091;
            5'd5: r = 16'd2047;
            5'd6: r = 16'd1024;
            5'd7: r = 16'd512;
            5'd8: r = 16'd256;
            5'd9: r = 16'd128;
            5'd10: r = 16'd64;
            5'd11: r = 16'd32;
            5'd12: r = 16'd16;
            5'd13: r = 16'd8;
            5'd14: r = 16'd4;
            5'd15: r = 16'd2;
            5'd16: r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/cbo_cordic.sv
`timescale 1ns / 1ps

module cbo_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [cbo_pkg::ANG_W-1:0]  angle,
    output logic                              done,
    output logic signed [cbo_pkg::CQ_W-1:0]   cos_q30,
    output logic signed [cbo_pkg::CQ_W-1:0]   sin_q30
);
    import cbo_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    logic signed [CQ_W-1:0] x_reg, x_next, y_reg, y_next, sx, sy;
    logic signed [ANG_W-1:0] a_reg, a_next, a_fold, step_ang;
    logic [4:0] i_reg, i_next;
    logic run_reg, run_next, flip_reg, flip_next, done_reg, done_next, flip_in;

    always_comb
    begin
        a_fold = angle;
        flip_in = 1'b0;
        if (angle > HALF_PI_Q16)
        begin
            a_fold = angle - PI_Q16;
            flip_in = 1'b1;
        end
        else if (angle < -HALF_PI_Q16)
        begin
            a_fold = angle + PI_Q16;
            flip_in = 1'b1;
        end
        sx = x_reg >>> i_reg;
        sy = y_reg >>> i_reg;
        step_ang = signed'(ANG_W'(cbo_atan(i_reg)));
        x_next = x_reg;
        y_next = y_reg;
        a_next = a_reg;
        i_next = i_reg;
        run_next = run_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next = CORDIC_GAIN_Q30;
            y_next = '0;
            a_next = a_fold;
            flip_next = flip_in;
            i_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!a_reg[ANG_W-1])
            begin
                x_next = x_reg - sy;
                y_next = y_reg + sx;
                a_next = a_reg - step_ang;
            end
            else
            begin
                x_next = x_reg + sy;
                y_next = y_reg - sx;
                a_next = a_reg + step_ang;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == LAST_STEP)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
            flip_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            i_reg <= i_next;
            flip_reg <= flip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        a_reg <= a_next;
    end

    assign done = done_reg;
    assign cos_q30 = flip_reg ? -x_reg : x_reg;
    assign sin_q30 = flip_reg ? -y_reg : y_reg;

endmodule

// File: sv/cbo_mul.sv
`timescale 1ns / 1ps

module cbo_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic        done,
    output logic [63:0] product
);
    import cbo_pkg::*;

    logic [63:0] mcand_reg, mcand_next, acc_reg, acc_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [4:0] cnt_reg, cnt_next;
    logic run_reg, run_next, done_reg, done_next;

    always_comb
    begin
        mcand_next = mcand_reg;
        acc_next = acc_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            mcand_next = {32'd0, op_a};
            mplier_next = op_b;
            acc_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next = {mcand_reg[62:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[31:1]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        acc_reg <= acc_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign product = acc_reg;

endmodule

// File: sv/cbo_div.sv
`timescale 1ns / 1ps

module cbo_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [34:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [34:0] remainder
);
    import cbo_pkg::*;

    logic [63:0] dvd_reg, dvd_next;
    logic [34:0] rem_reg, rem_next, dsr_reg, dsr_next;
    logic [35:0] shifted, diff;
    logic [5:0] cnt_reg, cnt_next;
    logic run_reg, run_next, done_reg, done_next, ge;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[63]};
        diff = shifted - {1'b0, dsr_reg};
        ge = shifted >= {1'b0, dsr_reg};
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[34:0] : shifted[34:0];
            dvd_next = {dvd_reg[62:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quotient = dvd_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/can_bicycle_odometry_top.sv
`timescale 1ns / 1ps
// Dead reckoning from decoded CAN frames with a kinematic bicycle model.
// Input channel (in_valid / in_stall): one request is either a CAN frame
// (operation 0) or an odometry tick (operation 1). A frame whose identifier
// matches the speed or steering identifier updates the stored speed or
// steering angle in the cycle it is accepted and produces no result.
// A tick advances x, y and heading by one time step and produces one result
// on the output channel (out_valid / out_stall) with the new pose and the
// half-heading quaternion terms.
// A tick runs from acceptance to out_valid as three CORDIC passes, five
// bit-serial multiplies, four or five bit-serial divisions (the tangent
// division only when the steering cosine is positive) and a load of the
// result register, all run one after another. Input stays stalled while
// a tick is in progress; frames are taken one per cycle while idle.
// The result sits in an output register; frames are accepted while it waits,
// and a finished tick holds until the previous result has been taken.
// Reset clears the pose, speed and steering to zero, loads the default
// identifiers, wheelbase and tick length, and drops out_valid.
// Configuration writes take effect at once; the user must make them while idle, as the block does not enforce it.

module can_bicycle_odometry_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  cbo_pkg::cfg_index_t         cfg_index,
    input  logic [13:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [10:0]                 can_id,
    input  logic [7:0]                  data_byte2,
    input  logic [7:0]                  data_byte3,
    input  logic [7:0]                  data_byte4,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          pos_x,
    output logic signed [31:0]          pos_y,
    output logic signed [18:0]          heading,
    output logic signed [15:0]          orient_z,
    output logic signed [15:0]          orient_w
);
    import cbo_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CYAW,
        ST_MVT,
        ST_MLEN,
        ST_MX,
        ST_DX,
        ST_MY,
        ST_DY,
        ST_CSTR,
        ST_DTAN,
        ST_MTAN,
        ST_DTH,
        ST_WRAP,
        ST_CHALF,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [10:0] speed_id_reg, steer_id_reg;
    logic [13:0] wheelbase_reg;
    logic [9:0] tick_ms_reg;
    logic signed [15:0] speed_reg, speed_next;
    logic signed [16:0] steer_reg, steer_next;
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic signed [18:0] yaw_reg, yaw_next;
    logic signed [CQ_W-1:0] c_reg, c_next, s_reg, s_next;
    logic [25:0] avt_reg, avt_next;
    logic [23:0] lenk_reg, lenk_next;
    logic tneg_reg, tneg_next, uneg_reg, uneg_next;
    logic out_valid_reg, out_valid_next;
    logic signed [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [18:0] heading_reg, heading_next;
    logic signed [15:0] oz_reg, oz_next, ow_reg, ow_next;

    logic cor_start, cor_done, mul_start, mul_done, div_start, div_done;
    logic signed [ANG_W-1:0] cor_angle;
    logic signed [CQ_W-1:0] cor_cos, cor_sin;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p, div_dvd, div_quot;
    logic [34:0] div_dsr, div_rem;

    logic accept;
    logic [15:0] av, raw;
    logic [9:0] raw_c;
    logic signed [10:0] sd;
    logic [8:0] sd_mag;
    logic [31:0] steer_prod;
    logic [13:0] len_eff;
    logic [CQ_W-1:0] c_mag, s_mag;
    logic signed [33:0] dq, dsum, dth, u;
    logic [33:0] u_mag;
    logic [18:0] wr_r, wr_t;
    logic signed [19:0] yaw_w;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -34'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_q15(input logic signed [CQ_W-1:0] q30);
        logic signed [CQ_W:0] t;
        logic signed [CQ_W:0] sh;
        logic signed [15:0] r;
        t = (CQ_W+1)'(q30) + 34'sd16384;
        sh = t >>> 15;
        if (sh > 34'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (sh < -34'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = sh[15:0];
        end
        return r;
    endfunction

    cbo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_q30 (cor_cos),
        .sin_q30 (cor_sin)
    );

    cbo_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    cbo_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        accept = in_valid && (state_reg == ST_IDLE);
        av = speed_reg[15] ? 16'(-speed_reg) : 16'(speed_reg);
        len_eff = (wheelbase_reg == 14'd0) ? 14'd1 : wheelbase_reg;
        c_mag = c_reg[CQ_W-1] ? CQ_W'(-c_reg) : CQ_W'(c_reg);
        s_mag = s_reg[CQ_W-1] ? CQ_W'(-s_reg) : CQ_W'(s_reg);

        raw = {data_byte3, data_byte4};
        raw_c = (raw > STEER_RAW_MAX) ? STEER_RAW_MAX[9:0] : raw[9:0];
        sd = signed'({1'b0, raw_c}) - STEER_RAW_MID;
        sd_mag = sd[10] ? 9'(-sd) : 9'(sd);
        steer_prod = 32'(sd_mag) * STEER_K + 32'd32768;

        dq = signed'(div_quot[33:0]);
        dsum = '0;
        dth = '0;
        u = '0;
        u_mag = '0;
        wr_r = div_rem[18:0];
        wr_t = (uneg_reg && wr_r != 19'd0) ? TWO_PI_Q16[18:0] - wr_r : wr_r;
        yaw_w = signed'({1'b0, wr_t}) - PI_Q16;

        state_next = state_reg;
        speed_next = speed_reg;
        steer_next = steer_reg;
        x_next = x_reg;
        y_next = y_reg;
        yaw_next = yaw_reg;
        c_next = c_reg;
        s_next = s_reg;
        avt_next = avt_reg;
        lenk_next = lenk_reg;
        tneg_next = tneg_reg;
        uneg_next = uneg_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        heading_next = heading_reg;
        oz_next = oz_reg;
        ow_next = ow_reg;
        out_valid_next = out_valid_reg && out_stall;

        cor_start = 1'b0;
        cor_angle = {yaw_reg[18], yaw_reg};
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        div_start = 1'b0;
        div_dvd = '0;
        div_dsr = POS_DEN;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_FRAME)
                    begin
                        if (can_id == speed_id_reg)
                        begin
                            speed_next = signed'({data_byte2, data_byte3});
                        end
                        if (can_id == steer_id_reg)
                        begin
                            steer_next = sd[10] ? -signed'({1'b0, steer_prod[31:16]})
                                                :  signed'({1'b0, steer_prod[31:16]});
                        end
                    end
                    else
                    begin
                        cor_start = 1'b1;
                        state_next = ST_CYAW;
                    end
                end
            end
            ST_CYAW:
            begin
                if (cor_done)
                begin
                    c_next = cor_cos;
                    s_next = cor_sin;
                    mul_start = 1'b1;
                    mul_a = 32'(av);
                    mul_b = 32'(tick_ms_reg);
                    state_next = ST_MVT;
                end
            end
            ST_MVT:
            begin
                if (mul_done)
                begin
                    avt_next = mul_p[25:0];
                    mul_start = 1'b1;
                    mul_a = 32'(len_eff);
                    mul_b = LEN_SCALE;
                    state_next = ST_MLEN;
                end
            end
            ST_MLEN:
            begin
                if (mul_done)
                begin
                    lenk_next = mul_p[23:0];
                    mul_start = 1'b1;
                    mul_a = 32'(avt_reg);
                    mul_b = c_mag[31:0];
                    state_next = ST_MX;
                end
            end
            ST_MX:
            begin
                if (mul_done)
                begin
                    div_start = 1'b1;
                    div_dvd = mul_p + POS_HALF;
                    div_dsr = POS_DEN;
                    state_next = ST_DX;
                end
            end
            ST_DX:
            begin
                if (div_done)
                begin
                    dsum = signed'({{2{x_reg[31]}}, x_reg})
                         + ((speed_reg[15] != c_reg[CQ_W-1]) ? -dq : dq);
                    x_next = sat32(dsum);
                    mul_start = 1'b1;
                    mul_a = 32'(avt_reg);
                    mul_b = s_mag[31:0];
                    state_next = ST_MY;
                end
            end
            ST_MY:
            begin
                if (mul_done)
                begin
                    div_start = 1'b1;
                    div_dvd = mul_p + POS_HALF;
                    div_dsr = POS_DEN;
                    state_next = ST_DY;
                end
            end
            ST_DY:
            begin
                if (div_done)
                begin
                    dsum = signed'({{2{y_reg[31]}}, y_reg})
                         + ((speed_reg[15] != s_reg[CQ_W-1]) ? -dq : dq);
                    y_next = sat32(dsum);
                    cor_start = 1'b1;
                    cor_angle = {{3{steer_reg[16]}}, steer_reg};
                    state_next = ST_CSTR;
                end
            end
            ST_CSTR:
            begin
                if (cor_done)
                begin
                    c_next = cor_cos;
                    s_next = cor_sin;
                    if (cor_cos > 0)
                    begin
                        div_start = 1'b1;
                        div_dvd = (64'(cor_sin[CQ_W-1] ? CQ_W'(-cor_sin) : CQ_W'(cor_sin)) << 16)
                                + 64'(CQ_W'(cor_cos) >> 1);
                        div_dsr = 35'(CQ_W'(cor_cos));
                        state_next = ST_DTAN;
                    end
                    else
                    begin
                        tneg_next = 1'b0;
                        mul_start = 1'b1;
                        mul_a = 32'(avt_reg);
                        mul_b = '0;
                        state_next = ST_MTAN;
                    end
                end
            end
            ST_DTAN:
            begin
                if (div_done)
                begin
                    tneg_next = s_reg[CQ_W-1] && (div_quot != 64'd0);
                    mul_start = 1'b1;
                    mul_a = 32'(avt_reg);
                    mul_b = div_quot[31:0];
                    state_next = ST_MTAN;
                end
            end
            ST_MTAN:
            begin
                if (mul_done)
                begin
                    div_start = 1'b1;
                    div_dvd = mul_p + 64'(lenk_reg >> 1);
                    div_dsr = 35'(lenk_reg);
                    state_next = ST_DTH;
                end
            end
            ST_DTH:
            begin
                if (div_done)
                begin
                    dth = (speed_reg[15] != tneg_reg) ? -dq : dq;
                    u = signed'({{15{yaw_reg[18]}}, yaw_reg}) + dth + 34'(PI_Q16);
                    u_mag = u[33] ? 34'(-u) : 34'(u);
                    uneg_next = u[33];
                    div_start = 1'b1;
                    div_dvd = 64'(u_mag);
                    div_dsr = TWO_PI_Q16;
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (div_done)
                begin
                    yaw_next = yaw_w[18:0];
                    cor_start = 1'b1;
                    cor_angle = {{2{yaw_w[18]}}, yaw_w[18:1]};
                    state_next = ST_CHALF;
                end
            end
            ST_CHALF:
            begin
                if (cor_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    pos_x_next = x_reg;
                    pos_y_next = y_reg;
                    heading_next = yaw_reg;
                    oz_next = to_q15(cor_sin);
                    ow_next = to_q15(cor_cos);
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            speed_id_reg <= 11'd1285;
            steer_id_reg <= 11'd1282;
            wheelbase_reg <= 14'd2500;
            tick_ms_reg <= 10'd100;
            speed_reg <= '0;
            steer_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            yaw_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            speed_reg <= speed_next;
            steer_reg <= steer_next;
            x_reg <= x_next;
            y_reg <= y_next;
            yaw_reg <= yaw_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPEED_ID: speed_id_reg <= cfg_data[10:0];
                    CFG_STEER_ID: steer_id_reg <= cfg_data[10:0];
                    CFG_WHEELBASE: wheelbase_reg <= cfg_data;
                    CFG_TICK_MS: tick_ms_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        s_reg <= s_next;
        avt_reg <= avt_next;
        lenk_reg <= lenk_next;
        tneg_reg <= tneg_next;
        uneg_reg <= uneg_next;
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        heading_reg <= heading_next;
        oz_reg <= oz_next;
        ow_reg <= ow_next;
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign heading = heading_reg;
    assign orient_z = oz_reg;
    assign orient_w = ow_reg;

endmodule

// File: sv/cbo_checker.sv
`timescale 1ns / 1ps

module cbo_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               operation,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] pos_x,
    input logic signed [18:0] heading
);
    import cbo_pkg::*;

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == OP_TICK |=> in_stall)
        else $error("tick request did not hold off the input");

    a_frame_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == OP_FRAME |=> !in_stall)
        else $error("frame request left the input stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(heading))
        else $error("stalled result changed or vanished");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading <= HEADING_MAX && heading >= -HEADING_MAX)
        else $error("heading outside the wrapped range");

endmodule

bind can_bicycle_odometry_top cbo_checker u_cbo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .heading   (heading)
);
